/* hw/rtl/i2ra_pkg.sv */
// Shared types, constants and the digit-to-ASCII mapping for the radix converter.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package i2ra_pkg;

   localparam int VALUE_BITS = 31;
   localparam int RADIX_W    = 6;
   localparam int CHAR_W     = 7;
   localparam int CNT_W      = $clog2(VALUE_BITS);
   localparam int DEPTH_W    = $clog2(VALUE_BITS + 1);
   localparam int REQ_W      = ((VALUE_BITS + RADIX_W + 7) / 8) * 8;
   localparam int RSP_W      = ((CHAR_W + 7) / 8) * 8;

   localparam logic [RADIX_W-1:0] RADIX_MIN  = RADIX_W'(2);
   localparam logic [RADIX_W-1:0] RADIX_MAX  = RADIX_W'(36);
   localparam logic [CHAR_W-1:0]  ASCII_ZERO = CHAR_W'(48);
   localparam logic [CHAR_W-1:0]  ASCII_NINE = CHAR_W'(57);
   localparam logic [CHAR_W-1:0]  ALPHA_GAP  = CHAR_W'(39);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic                  start;
      logic [VALUE_BITS-1:0] dividend;
      logic [RADIX_W-1:0]    radix;
   } div_ctrl_type;

   typedef struct packed {
      logic                  busy;
      logic                  done;
      logic [VALUE_BITS-1:0] quotient;
      logic [RADIX_W-1:0]    remainder;
   } div_stat_type;

   typedef struct packed {
      logic               push;
      logic               pop;
      logic [RADIX_W-1:0] digit;
   } stk_ctrl_type;

   typedef struct packed {
      logic               empty;
      logic               one_left;
      logic [RADIX_W-1:0] top;
   } stk_stat_type;

   function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [RADIX_W-1:0] d);
      logic [CHAR_W-1:0] c;
      c = CHAR_W'(d) + ASCII_ZERO;
      if (c > ASCII_NINE) begin
         c = c + ALPHA_GAP;
      end
      return c;
   endfunction

endpackage

/* hw/rtl/integer_to_radix_ascii.sv */
// Top level of the integer to radix ASCII converter: sequencer and result register.
// Depends on i2ra_pkg, i2ra_divider and i2ra_stack.
//
// Usage:
//   req channel: one word carries value (31 bits) and radix (6 bits). Radix
//   below 2 is taken as 2, above 36 as 36.
//   rsp channel: one word per digit, most significant first, ASCII '0'-'9'
//   then 'a'-'z'; tlast marks the least significant digit. Zero gives '0'.
//   Timing: each digit costs one bit-serial division in the shift-subtract
//   divider. Once all digits of an item are converted, one digit per cycle
//   leaves through the output register while rsp_tready does not stall it.
//   One item is converted at a time; req_tready is high only when idle.
//   A new item may be accepted while the final digit still waits in the
//   output register.
//   Reset: synchronous, active high; clears the sequencer, divider and stack.
//   Stall: while rsp_tready is low the output word holds and the stack
//   keeps its digits.
`timescale 1ns / 1ps

module integer_to_radix_ascii
   import i2ra_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [REQ_W-1:0] req_tdata,  // value [30:0], radix [36:31], zero fill
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata,  // digit_char [6:0], zero fill
   output logic             rsp_tlast   // last
);

   state_type          state_ff, state_in;
   logic [RADIX_W-1:0] radix_ff, radix_in;
   logic [RADIX_W-1:0] req_radix;
   logic               out_valid_ff, out_valid_in;
   logic [CHAR_W-1:0]  out_char_ff, out_char_in;
   logic               out_last_ff, out_last_in;
   logic               out_free;
   div_ctrl_type       div_ctrl;
   div_stat_type       div_stat;
   stk_ctrl_type       stk_ctrl;
   stk_stat_type       stk_stat;

   i2ra_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .div_ctrl (div_ctrl),
      .div_stat (div_stat)
   );

   i2ra_stack u_stack (
      .clock    (clock),
      .reset    (reset),
      .stk_ctrl (stk_ctrl),
      .stk_stat (stk_stat)
   );

   always_comb begin
      req_radix = req_tdata[VALUE_BITS +: RADIX_W];
      if (req_radix < RADIX_MIN) begin
         req_radix = RADIX_MIN;
      end else if (req_radix > RADIX_MAX) begin
         req_radix = RADIX_MAX;
      end
   end

   assign out_free = !out_valid_ff || rsp_tready;

   always_comb begin
      state_in          = state_ff;
      radix_in          = radix_ff;
      req_tready        = 1'b0;
      div_ctrl.start    = 1'b0;
      div_ctrl.dividend = div_stat.quotient;
      div_ctrl.radix    = radix_ff;
      stk_ctrl.push     = 1'b0;
      stk_ctrl.pop      = 1'b0;
      stk_ctrl.digit    = div_stat.remainder;
      out_valid_in      = out_valid_ff && !rsp_tready;
      out_char_in       = out_char_ff;
      out_last_in       = out_last_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               radix_in          = req_radix;
               div_ctrl.start    = 1'b1;
               div_ctrl.dividend = req_tdata[VALUE_BITS-1:0];
               div_ctrl.radix    = req_radix;
               state_in          = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (div_stat.done) begin
               stk_ctrl.push = 1'b1;
               if (div_stat.quotient == '0) begin
                  state_in = ST_EMIT;
               end else begin
                  div_ctrl.start = 1'b1;
               end
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               stk_ctrl.pop = 1'b1;
               out_valid_in = 1'b1;
               out_char_in  = digit_to_ascii(stk_stat.top);
               out_last_in  = stk_stat.one_left;
               if (stk_stat.one_left) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
      radix_ff    <= radix_in;
      out_char_ff <= out_char_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = RSP_W'(out_char_ff);
   assign rsp_tlast  = out_last_ff;

`ifndef ASSERT_OFF
   a_accept_starts_divide: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == ST_DIVIDE))
      else $error("accepted word did not start a division");

   a_emit_divider_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> !div_stat.busy)
      else $error("divider busy while emitting digits");

   a_last_empties_stack: assert property (@(posedge clock) disable iff (reset)
      (stk_ctrl.pop && stk_stat.one_left) |=> stk_stat.empty)
      else $error("digits left on stack after final digit");

   a_emit_not_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> !stk_stat.empty)
      else $error("emit state with empty digit stack");
`endif

endmodule

/* hw/rtl/i2ra_divider.sv */
// Bit-serial restoring divider: one quotient bit per cycle for a VALUE_BITS-bit dividend.
// Depends on i2ra_pkg.
`timescale 1ns / 1ps

module i2ra_divider
   import i2ra_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  div_ctrl_type div_ctrl,
   output div_stat_type div_stat
);

   logic                  running_ff, running_in;
   logic                  done_ff, done_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [VALUE_BITS-1:0] quot_ff, quot_in;
   logic [RADIX_W-1:0]    rem_ff, rem_in;
   logic [RADIX_W-1:0]    radix_ff, radix_in;
   logic [RADIX_W:0]      trial;
   logic                  fits;

   always_comb begin
      trial      = {rem_ff, quot_ff[VALUE_BITS-1]};
      fits       = trial >= {1'b0, radix_ff};
      running_in = running_ff;
      done_in    = 1'b0;
      cnt_in     = cnt_ff;
      quot_in    = quot_ff;
      rem_in     = rem_ff;
      radix_in   = radix_ff;
      if (div_ctrl.start) begin
         running_in = 1'b1;
         cnt_in     = '0;
         quot_in    = div_ctrl.dividend;
         rem_in     = '0;
         radix_in   = div_ctrl.radix;
      end else if (running_ff) begin
         quot_in = {quot_ff[VALUE_BITS-2:0], fits};
         rem_in  = fits ? RADIX_W'(trial - {1'b0, radix_ff}) : trial[RADIX_W-1:0];
         cnt_in  = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(VALUE_BITS - 1)) begin
            running_in = 1'b0;
            done_in    = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= 1'b0;
         done_ff    <= 1'b0;
         cnt_ff     <= '0;
      end else begin
         running_ff <= running_in;
         done_ff    <= done_in;
         cnt_ff     <= cnt_in;
      end
      quot_ff  <= quot_in;
      rem_ff   <= rem_in;
      radix_ff <= radix_in;
   end

   assign div_stat.busy      = running_ff;
   assign div_stat.done      = done_ff;
   assign div_stat.quotient  = quot_ff;
   assign div_stat.remainder = rem_ff;

endmodule

/* hw/rtl/i2ra_stack.sv */
// Digit stack built as a shift register: push shifts up, pop shifts down.
// Depends on i2ra_pkg.
`timescale 1ns / 1ps

module i2ra_stack
   import i2ra_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  stk_ctrl_type stk_ctrl,
   output stk_stat_type stk_stat
);

   logic [RADIX_W-1:0] slot_ff [VALUE_BITS];
   logic [RADIX_W-1:0] slot_in [VALUE_BITS];
   logic [DEPTH_W-1:0] count_ff, count_in;

   always_comb begin
      count_in = count_ff;
      for (int i = 0; i < VALUE_BITS; i++) begin
         slot_in[i] = slot_ff[i];
      end
      if (stk_ctrl.push) begin
         slot_in[0] = stk_ctrl.digit;
         for (int i = 1; i < VALUE_BITS; i++) begin
            slot_in[i] = slot_ff[i-1];
         end
         count_in = count_ff + DEPTH_W'(1);
      end else if (stk_ctrl.pop) begin
         for (int i = 0; i < VALUE_BITS - 1; i++) begin
            slot_in[i] = slot_ff[i+1];
         end
         count_in = count_ff - DEPTH_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      for (int i = 0; i < VALUE_BITS; i++) begin
         slot_ff[i] <= slot_in[i];
      end
   end

   assign stk_stat.empty    = count_ff == '0;
   assign stk_stat.one_left = count_ff == DEPTH_W'(1);
   assign stk_stat.top      = slot_ff[0];

endmodule

/* sim/radix_digit_checker.sv */
// Checker for the radix converter: predicts the digit words of every accepted value and
// compares them with the words that leave the rsp channel. Depends on i2ra_pkg.
`timescale 1ns / 1ps

module radix_digit_checker
   import i2ra_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   input  logic             req_tready,
   input  logic [REQ_W-1:0] req_tdata,  // value [30:0], radix [36:31], zero fill
   input  logic             rsp_tvalid,
   input  logic             rsp_tready,
   input  logic [RSP_W-1:0] rsp_tdata,  // digit_char [6:0], zero fill
   input  logic             rsp_tlast,  // last
   output int               error_count,
   output int               words_checked,
   output int               pending_digits
);

   typedef struct packed {
      logic [CHAR_W-1:0] digit_char;
      logic              last;
   } digit_word_type;

   digit_word_type digit_queue[$];

   initial begin
      error_count    = 0;
      words_checked  = 0;
      pending_digits = 0;
   end

   function automatic logic [CHAR_W-1:0] char_of_digit(input int unsigned d);
      if (d < 10) begin
         return CHAR_W'("0") + CHAR_W'(d);
      end
      return CHAR_W'("a") + CHAR_W'(d - 10);
   endfunction

   // split the value into digits of the clamped radix, most significant first
   function automatic void predict_digits(input logic [VALUE_BITS-1:0] value,
                                          input logic [RADIX_W-1:0] radix);
      logic [VALUE_BITS-1:0] rest;
      int unsigned           base;
      int unsigned           digits[$];
      digit_word_type        word;
      rest = value;
      base = 32'(radix);
      if (base < RADIX_MIN) begin
         base = 32'(RADIX_MIN);
      end
      if (base > RADIX_MAX) begin
         base = 32'(RADIX_MAX);
      end
      do begin
         digits.push_front(rest % base);
         rest = VALUE_BITS'(rest / base);
      end while (rest != 0);
      foreach (digits[k]) begin
         word.digit_char = char_of_digit(digits[k]);
         word.last       = (k == digits.size() - 1);
         digit_queue.push_back(word);
      end
   endfunction

   always @(posedge clock) begin
      digit_word_type expected;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            predict_digits(req_tdata[VALUE_BITS-1:0],
                           req_tdata[VALUE_BITS +: RADIX_W]);
         end
         if (rsp_tvalid && rsp_tready) begin
            words_checked++;
            if (digit_queue.size() == 0) begin
               error_count++;
               if (error_count <= 10) begin
                  $display("%0t ERROR: unexpected word char=%02h last=%0b",
                           $time, rsp_tdata[CHAR_W-1:0], rsp_tlast);
               end
            end else begin
               expected = digit_queue.pop_front();
               if (rsp_tdata[CHAR_W-1:0] !== expected.digit_char ||
                   rsp_tlast !== expected.last) begin
                  error_count++;
                  if (error_count <= 10) begin
                     $display("%0t ERROR: char exp %02h got %02h, last exp %0b got %0b",
                              $time, expected.digit_char, rsp_tdata[CHAR_W-1:0],
                              expected.last, rsp_tlast);
                  end
               end
            end
         end
      end
      pending_digits <= digit_queue.size();
   end

endmodule

/* sim/tb_top.sv */
// Top of the radix converter testbench: clock, reset, value stimulus, rsp backpressure
// and the verdict. Depends on i2ra_pkg, integer_to_radix_ascii and radix_digit_checker.
`timescale 1ns / 1ps

module tb_top
   import i2ra_pkg::*;
();

   localparam int STALL_LIMIT  = 16000;
   localparam int RANDOM_ITEMS = 350;
   localparam int HOLD_CYCLES  = 3000;

   logic             clock      = 1'b0;
   logic             reset      = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata  = '0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;
   logic             rsp_tlast;

   int error_count;
   int words_checked;
   int pending_digits;
   int items_sent = 0;

   integer_to_radix_ascii dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   radix_digit_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tlast      (rsp_tlast),
      .error_count    (error_count),
      .words_checked  (words_checked),
      .pending_digits (pending_digits)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   task automatic send_value(input logic [VALUE_BITS-1:0] value,
                             input logic [RADIX_W-1:0] radix, input bit may_idle);
      while (may_idle && $urandom_range(99) < 21) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tdata  <= REQ_W'({radix, value});
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      items_sent++;
   endtask

   // drop valid and hold until every predicted digit has left the block
   task automatic drain_digits();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_digits != 0);
   endtask

   initial begin
      logic [VALUE_BITS-1:0] value;
      logic [RADIX_W-1:0]    radix;
      int                    width;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_value(31'd0, 6'd10, 1'b1);
      send_value(31'd0, 6'd2, 1'b1);
      send_value(31'h7FFF_FFFF, 6'd2, 1'b1);
      send_value(31'h7FFF_FFFF, 6'd36, 1'b1);
      send_value(31'h7FFF_FFFF, 6'd0, 1'b1);
      send_value(31'h7FFF_FFFF, 6'd1, 1'b1);
      send_value(31'd12345, 6'd37, 1'b1);
      send_value(31'h7FFF_FFFF, 6'd63, 1'b1);
      send_value(31'd35, 6'd36, 1'b1);
      send_value(31'd9, 6'd10, 1'b1);
      send_value(31'd10, 6'd11, 1'b1);
      send_value(31'd10, 6'd16, 1'b1);
      send_value(31'd255, 6'd16, 1'b1);
      send_value(31'd1, 6'd2, 1'b1);
      send_value(31'd1, 6'd36, 1'b1);
      send_value(31'd36, 6'd36, 1'b1);
      send_value(31'd1295, 6'd36, 1'b1);
      send_value(31'd1000000000, 6'd10, 1'b1);
      send_value(31'h4000_0000, 6'd2, 1'b1);
      send_value(31'h2AAA_AAAA, 6'd4, 1'b1);
      send_value(31'd1, 6'd63, 1'b1);
      send_value(31'd0, 6'd63, 1'b1);
      send_value(31'd0, 6'd0, 1'b1);
      send_value(31'd123456789, 6'd7, 1'b1);
      send_value(31'h7FFF_FFFE, 6'd3, 1'b1);
      drain_digits();

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         width = $urandom_range(VALUE_BITS, 1);
         value = VALUE_BITS'($urandom) & VALUE_BITS'((64'd1 << width) - 1);
         if ($urandom_range(99) < 85) begin
            radix = RADIX_W'($urandom_range(36, 2));
         end else begin
            radix = RADIX_W'($urandom_range(63, 0));
         end
         send_value(value, radix, !(n >= 150 && n < 230));
         if (n == 100) begin
            drain_digits();
         end
      end
      drain_digits();
      repeat (64) @(posedge clock);

      $display("Converted %0d values (zero, radix clamps, 1 to 31 digits), checked %0d words",
               items_sent, words_checked);
      $display("with random idling, a %0d-cycle rsp hold-off and full drains",
               HOLD_CYCLES);
      if (error_count == 0 && pending_digits == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // rsp backpressure: random stalls, one long hold-off, one stall-free stretch
   initial begin
      int words_taken;
      int hold_left;
      bit held;
      words_taken = 0;
      hold_left   = 0;
      held        = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) begin
            words_taken++;
         end
         if (!held && words_taken >= 300) begin
            held      = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (words_taken >= 1000 && words_taken < 1600) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= ($urandom_range(99) >= 21);
         end
      end
   end

   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
      $display("Timeout: no word accepted for %0d cycles", STALL_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

/* filelist.f */
hw/rtl/i2ra_pkg.sv
hw/rtl/i2ra_divider.sv
hw/rtl/i2ra_stack.sv
hw/rtl/integer_to_radix_ascii.sv
sim/radix_digit_checker.sv
sim/tb_top.sv
